[rtl/tone_code_run_deframer_top_defines.svh]
// Assertion macros for the tone code run deframer.
// Included by the top level; no other dependencies.
`ifndef TONE_CODE_RUN_DEFRAMER_TOP_DEFINES_SVH
`define TONE_CODE_RUN_DEFRAMER_TOP_DEFINES_SVH
`ifndef SYNTH
`define TCRD_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("tcrd assertion failed");
`define TCRD_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("tcrd invariant failed");
`else
`define TCRD_ASSERT(lbl, prop)
`define TCRD_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

[rtl/tcrd_pkg.sv]
// Shared constants, types and codes for the tone code run deframer.
// No dependencies.
`default_nettype none
package tcrd_pkg;
	localparam int NUM_TONES  = 7;
	localparam int COUNT_BITS = 12;
	localparam int CODE_TONES = (NUM_TONES < 7) ? NUM_TONES : 7;
	localparam int TONE_IDX_W = (NUM_TONES > 1) ? $clog2(NUM_TONES) : 1;
	localparam int LIVE_W     = $clog2(NUM_TONES + 1);
	localparam int WINDOW     = 4;
	localparam int FILL_W     = 3;
	localparam int CODE_W     = 7;
	localparam int POS_W      = 32;
	localparam int TONES_W    = 3;
	localparam int GAP_CFG_W  = 24;
	localparam int CFG_IDX_W  = 2;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	localparam logic [TONES_W-1:0]   MAX_TONES_RESET  = 3'd2;
	localparam logic [CODE_W-1:0]    START_CODE_RESET = 7'd18;
	localparam logic [GAP_CFG_W-1:0] MAX_GAP_RESET    = 24'd40000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MAX_TONES  = 2'd0,
		CFG_START_CODE = 2'd1,
		CFG_MAX_GAP    = 2'd2
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PRUNE,
		ST_SHIFT,
		ST_CHECK,
		ST_EMIT
	} state_t;

	typedef logic [COUNT_BITS-1:0] count_t;
endpackage
`default_nettype wire

[rtl/tcrd_frame_if.sv]
// Input channel carrying one frame code and its sample position per beat.
// Depends on tcrd_pkg.
`default_nettype none
interface tcrd_frame_if import tcrd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CODE_W-1:0] frame_code;
	logic [POS_W-1:0]  frame_position;

	modport source (output valid, output frame_code, output frame_position, input ready);
	modport sink (input valid, input frame_code, input frame_position, output ready);
endinterface
`default_nettype wire

[rtl/tcrd_message_if.sv]
// Output channel carrying one decoded three-symbol message per beat.
// Depends on tcrd_pkg.
`default_nettype none
interface tcrd_message_if import tcrd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CODE_W-1:0] first_symbol;
	logic [CODE_W-1:0] second_symbol;
	logic [CODE_W-1:0] third_symbol;
	logic [POS_W-1:0]  start_position;

	modport source (output valid, output first_symbol, output second_symbol,
		output third_symbol, output start_position, input ready);
	modport sink (input valid, input first_symbol, input second_symbol,
		input third_symbol, input start_position, output ready);
endinterface
`default_nettype wire

[rtl/tcrd_cfg_if.sv]
// Configuration write channel: register index and write data per beat.
// Depends on tcrd_pkg.
`default_nettype none
interface tcrd_cfg_if import tcrd_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [GAP_CFG_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[rtl/tone_code_run_deframer_top.sv]
// Top level of the tone code run deframer: run counting, threshold pruning,
// symbol window and message match. Depends on tcrd_pkg and the channel interfaces.
// A nonzero code, or a zero code outside a run, is handled in the idle state; a closing
// zero code runs P = 1 to 8 pruning passes over one shared compare, then the window
// shift and gap checks, plus any wait for a busy output register.
// arst_n clears control state, counts and configuration; the window needs no reset.
`default_nettype none
`include "tone_code_run_deframer_top_defines.svh"
module tone_code_run_deframer_top import tcrd_pkg::*; (
	input  wire           clk,
	input  wire           arst_n,
	tcrd_frame_if.sink    frame,
	tcrd_message_if.source message,
	tcrd_cfg_if.sink      cfg
);
	state_t state_q, state_d;

	logic [TONES_W-1:0]   max_tones_q;
	logic [CODE_W-1:0]    start_code_q;
	logic [GAP_CFG_W-1:0] max_gap_q;

	logic                 in_run_q;
	logic [POS_W-1:0]     run_start_q;
	count_t               count_q [NUM_TONES];
	logic [CODE_W-1:0]    sym_q [WINDOW];
	logic [POS_W-1:0]     pos_q [WINDOW];
	logic [POS_W-1:0]     gap_q [WINDOW-1];
	logic [FILL_W-1:0]    fill_q;

	logic [TONE_IDX_W-1:0] idx_q;
	count_t               thd_q;
	count_t               min_q;
	logic [LIVE_W-1:0]    live_q;
	logic [1:0]           chk_q;

	logic                 out_valid_q;
	logic [CODE_W-1:0]    out_first_q, out_second_q, out_third_q;
	logic [POS_W-1:0]     out_pos_q;

	logic                 frame_take, code_nz;
	count_t               cnt_cur, min_next;
	logic                 keep;
	logic [LIVE_W-1:0]    live_next;
	logic                 pass_last, pass_done;
	logic [CODE_W-1:0]    sym_new;
	logic [POS_W-1:0]     gap_new, gap_sel;
	logic                 window_ok, gap_bad, out_free;
	logic                 counts_zero;

	assign frame_take = frame.valid && frame.ready;
	assign code_nz    = frame.frame_code != '0;

	assign cnt_cur   = count_q[idx_q];
	assign keep      = cnt_cur > thd_q;
	assign live_next = live_q + LIVE_W'(keep);
	assign min_next  = (keep && (cnt_cur < min_q)) ? cnt_cur : min_q;
	assign pass_last = idx_q == TONE_IDX_W'(NUM_TONES - 1);
	assign pass_done = 32'(live_next) <= 32'(max_tones_q);

	always_comb begin
		sym_new = '0;
		counts_zero = 1'b1;
		for (int b = 0; b < NUM_TONES; b++) begin
			if (count_q[b] != '0) counts_zero = 1'b0;
		end
		for (int b = 0; b < CODE_TONES; b++) begin
			sym_new[b] = count_q[b] != '0;
		end
	end

	assign gap_new = (run_start_q >= pos_q[WINDOW-1]) ? run_start_q - pos_q[WINDOW-1]
		: pos_q[WINDOW-1] - run_start_q;

	always_comb begin
		case (chk_q)
			2'd0: gap_sel = gap_q[0];
			2'd1: gap_sel = gap_q[1];
			default: gap_sel = gap_q[2];
		endcase
	end

	assign window_ok = (fill_q == FILL_W'(WINDOW)) && (sym_q[0] == start_code_q);
	assign gap_bad   = gap_sel > POS_W'(max_gap_q);
	assign out_free  = !out_valid_q || message.ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (frame_take && !code_nz && in_run_q) state_d = ST_PRUNE;
			end
			ST_PRUNE: begin
				if (pass_last && pass_done) state_d = ST_SHIFT;
			end
			ST_SHIFT: state_d = ST_CHECK;
			ST_CHECK: begin
				if (!window_ok || gap_bad) state_d = ST_IDLE;
				else if (chk_q == 2'd2) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		frame.ready          = state_q == ST_IDLE;
		cfg.ready            = 1'b1;
		message.valid        = out_valid_q;
		message.first_symbol  = out_first_q;
		message.second_symbol = out_second_q;
		message.third_symbol  = out_third_q;
		message.start_position = out_pos_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			max_tones_q  <= MAX_TONES_RESET;
			start_code_q <= START_CODE_RESET;
			max_gap_q    <= MAX_GAP_RESET;
			in_run_q     <= 1'b0;
			run_start_q  <= '0;
			fill_q       <= '0;
			idx_q        <= '0;
			thd_q        <= '0;
			min_q        <= COUNT_MAX;
			live_q       <= '0;
			chk_q        <= '0;
			out_valid_q  <= 1'b0;
			for (int b = 0; b < NUM_TONES; b++) count_q[b] <= '0;
		end else begin
			state_q <= state_d;

			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_MAX_TONES:  max_tones_q  <= cfg.data[TONES_W-1:0];
					CFG_START_CODE: start_code_q <= cfg.data[CODE_W-1:0];
					CFG_MAX_GAP:    max_gap_q    <= cfg.data;
					default: ;
				endcase
			end

			if (state_q == ST_EMIT && out_free) out_valid_q <= 1'b1;
			else if (out_valid_q && message.ready) out_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					idx_q  <= '0;
					thd_q  <= '0;
					live_q <= '0;
					min_q  <= COUNT_MAX;
					if (frame_take && code_nz) begin
						in_run_q <= 1'b1;
						if (!in_run_q) run_start_q <= frame.frame_position;
						for (int b = 0; b < NUM_TONES; b++) begin
							if (b < CODE_TONES && frame.frame_code[b % CODE_W]) begin
								if (!in_run_q) count_q[b] <= count_t'(1);
								else if (count_q[b] != COUNT_MAX)
									count_q[b] <= count_q[b] + count_t'(1);
							end else if (!in_run_q) begin
								count_q[b] <= '0;
							end
						end
					end else if (frame_take && in_run_q) begin
						in_run_q <= 1'b0;
					end
				end
				ST_PRUNE: begin
					if (!keep) count_q[idx_q] <= '0;
					if (pass_last) begin
						idx_q  <= '0;
						live_q <= '0;
						min_q  <= COUNT_MAX;
						if (!pass_done) thd_q <= min_next;
					end else begin
						idx_q  <= idx_q + TONE_IDX_W'(1);
						live_q <= live_next;
						min_q  <= min_next;
					end
				end
				ST_SHIFT: begin
					for (int b = 0; b < NUM_TONES; b++) count_q[b] <= '0;
					if (fill_q != FILL_W'(WINDOW)) fill_q <= fill_q + FILL_W'(1);
					chk_q <= '0;
				end
				ST_CHECK: begin
					chk_q <= chk_q + 2'd1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SHIFT) begin
			for (int i = 0; i < WINDOW - 1; i++) begin
				sym_q[i] <= sym_q[i+1];
				pos_q[i] <= pos_q[i+1];
			end
			sym_q[WINDOW-1] <= sym_new;
			pos_q[WINDOW-1] <= run_start_q;
			for (int i = 0; i < WINDOW - 2; i++) gap_q[i] <= gap_q[i+1];
			gap_q[WINDOW-2] <= gap_new;
		end
		if (state_q == ST_EMIT && out_free) begin
			out_first_q  <= sym_q[1];
			out_second_q <= sym_q[2];
			out_third_q  <= sym_q[3];
			out_pos_q    <= pos_q[0];
		end
	end

	`TCRD_ASSERT_ALWAYS(a_fill_bound, (fill_q <= FILL_W'(WINDOW)))
	`TCRD_ASSERT_ALWAYS(a_live_bound, (live_q <= LIVE_W'(NUM_TONES)))
	`TCRD_ASSERT(a_counts_cleared, (state_q == ST_SHIFT) |=> counts_zero)
	`TCRD_ASSERT(a_emit_source, $rose(out_valid_q) |-> $past(state_q == ST_EMIT))
	`TCRD_ASSERT(a_thd_rises, (state_q == ST_PRUNE && idx_q == '0 && $past(state_q == ST_PRUNE)) |-> (thd_q > $past(thd_q)))
endmodule
`default_nettype wire

[tb/tone_code_run_deframer_checker.sv]
// Beat monitor and message predictor for the tone code run deframer.
// Watches the frame, message and configuration channels and counts mismatches.
// Depends on tcrd_pkg and the three channel interfaces.
`default_nettype none
module tone_code_run_deframer_checker import tcrd_pkg::*; (
	input  wire     clk,
	input  wire     arst_n,
	tcrd_frame_if   frame,
	tcrd_message_if message,
	tcrd_cfg_if     cfg,
	output int      fail_count,
	output int      pending
);
	typedef struct packed {
		logic [CODE_W-1:0] first_sym;
		logic [CODE_W-1:0] second_sym;
		logic [CODE_W-1:0] third_sym;
		logic [POS_W-1:0]  origin;
	} message_t;

	logic [TONES_W-1:0]   max_tones;
	logic [CODE_W-1:0]    start_code;
	logic [GAP_CFG_W-1:0] max_gap;
	logic                 run_open;
	logic [POS_W-1:0]     run_origin;
	count_t               tally [NUM_TONES];
	logic [CODE_W-1:0]    window_sym [WINDOW];
	logic [POS_W-1:0]     window_pos [WINDOW];
	int                   window_fill;
	message_t             expected_messages [$];

	function automatic logic [POS_W-1:0] position_gap(input logic [POS_W-1:0] a,
		input logic [POS_W-1:0] b);
		return (a >= b) ? a - b : b - a;
	endfunction

	// Raise the threshold until few enough tones are left, then read the symbol.
	function automatic logic [CODE_W-1:0] close_tone_run();
		int threshold;
		int live;
		int b;
		logic [CODE_W-1:0] symbol;
		threshold = 0;
		symbol = '0;
		do begin
			live = 0;
			for (b = 0; b < NUM_TONES; b++) begin
				if (tally[b] <= threshold)
					tally[b] = '0;
				if (tally[b] != '0)
					live++;
			end
			threshold++;
		end while (live > int'(max_tones));
		for (b = 0; b < CODE_TONES; b++)
			symbol[b] = (tally[b] != '0);
		for (b = 0; b < NUM_TONES; b++)
			tally[b] = '0;
		return symbol;
	endfunction

	task automatic predict_frame(input logic [CODE_W-1:0] code,
		input logic [POS_W-1:0] position);
		int b;
		logic [CODE_W-1:0] symbol;
		logic match;
		message_t entry;
		if (code != '0) begin
			if (!run_open) begin
				run_open = 1'b1;
				run_origin = position;
				for (b = 0; b < NUM_TONES; b++)
					tally[b] = '0;
			end
			for (b = 0; b < CODE_TONES; b++)
				if (code[b] && tally[b] != COUNT_MAX)
					tally[b] = tally[b] + 1'b1;
		end else if (run_open) begin
			run_open = 1'b0;
			symbol = close_tone_run();
			for (b = 0; b < WINDOW - 1; b++) begin
				window_sym[b] = window_sym[b + 1];
				window_pos[b] = window_pos[b + 1];
			end
			window_sym[WINDOW - 1] = symbol;
			window_pos[WINDOW - 1] = run_origin;
			if (window_fill < WINDOW)
				window_fill++;
			match = (window_fill == WINDOW) && (window_sym[0] == start_code);
			for (b = 0; b < WINDOW - 1; b++)
				if (match && position_gap(window_pos[b], window_pos[b + 1]) > max_gap)
					match = 1'b0;
			if (match) begin
				entry = {window_sym[1], window_sym[2], window_sym[3], window_pos[0]};
				expected_messages = {expected_messages, entry};
			end
		end
	endtask

	function automatic void compare_field(input string field, input logic [POS_W-1:0] want,
		input logic [POS_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0h actual %0h", $time, field, want, got);
			fail_count++;
		end
	endfunction

	task automatic check_message();
		message_t want;
		if (expected_messages.size() == 0) begin
			$display("%0t: message %0h %0h %0h at %0h arrived with none expected", $time,
				message.first_symbol, message.second_symbol, message.third_symbol,
				message.start_position);
			fail_count++;
		end else begin
			want = expected_messages.pop_front();
			compare_field("first_symbol", POS_W'(want.first_sym), POS_W'(message.first_symbol));
			compare_field("second_symbol", POS_W'(want.second_sym),
				POS_W'(message.second_symbol));
			compare_field("third_symbol", POS_W'(want.third_sym), POS_W'(message.third_symbol));
			compare_field("start_position", want.origin, message.start_position);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_tones = MAX_TONES_RESET;
			start_code = START_CODE_RESET;
			max_gap = MAX_GAP_RESET;
			run_open = 1'b0;
			run_origin = '0;
			for (int b = 0; b < NUM_TONES; b++)
				tally[b] = '0;
			for (int w = 0; w < WINDOW; w++) begin
				window_sym[w] = '0;
				window_pos[w] = '0;
			end
			window_fill = 0;
			expected_messages.delete();
			fail_count = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg_reg_t'(cfg.index))
					CFG_MAX_TONES: max_tones = cfg.data[TONES_W-1:0];
					CFG_START_CODE: start_code = cfg.data[CODE_W-1:0];
					CFG_MAX_GAP: max_gap = cfg.data;
					default: ;
				endcase
			end
			if (message.valid && message.ready)
				check_message();
			if (frame.valid && frame.ready)
				predict_frame(frame.frame_code, frame.frame_position);
		end
		pending = expected_messages.size();
	end
endmodule
`default_nettype wire

[tb/tone_code_run_deframer_top_test.sv]
// Stimulus and verdict for the tone code run deframer: directed runs, then
// randomized message phases under several register settings with back-pressure.
// Depends on tcrd_pkg, the channel interfaces, the block and the checker.
`default_nettype none
module tone_code_run_deframer_top_test import tcrd_pkg::*; ();
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES  = 80;
	localparam int HOLD_CYCLES    = 400;
	localparam logic [CODE_W-1:0] DIRECTED_CODES [24] = '{
		7'h00, 7'h12, 7'h12, 7'h00, 7'h7F, 7'h03, 7'h00, 7'h7F, 7'h00, 7'h40, 7'h00,
		7'h01, 7'h00, 7'h12, 7'h00, 7'h12, 7'h00, 7'h05, 7'h00, 7'h09, 7'h00, 7'h20,
		7'h00, 7'h00
	};

	logic              clk = 1'b0;
	logic              arst_n;
	int                fail_count;
	int                pending;
	int                counted_items = 0;
	logic              run_seen = 1'b0;
	logic [POS_W-1:0]  frame_pos = '0;
	int unsigned       pos_stride = 256;
	logic              pos_jumps = 1'b0;
	logic              frame_gaps = 1'b1;
	logic              message_gaps = 1'b1;
	int                hold_request = 0;
	int                holding = 0;
	int                quiet_cycles = 0;
	logic [CODE_W-1:0] start_now = START_CODE_RESET;

	tcrd_frame_if   frame_ch ();
	tcrd_message_if message_ch ();
	tcrd_cfg_if     cfg_ch ();

	tone_code_run_deframer_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.frame(frame_ch),
		.message(message_ch),
		.cfg(cfg_ch)
	);

	tone_code_run_deframer_checker message_check (
		.clk(clk),
		.arst_n(arst_n),
		.frame(frame_ch),
		.message(message_ch),
		.cfg(cfg_ch),
		.fail_count(fail_count),
		.pending(pending)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		if ((frame_ch.valid && frame_ch.ready) || (message_ch.valid && message_ch.ready) ||
			(cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		message_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request != 0) begin
				holding = hold_request;
				hold_request = 0;
			end
			if (holding > 0) begin
				holding--;
				message_ch.ready <= 1'b0;
			end else begin
				message_ch.ready <= !(message_gaps && $urandom_range(99) < 13);
			end
		end
	end

	task automatic advance_position();
		int unsigned roll;
		roll = $urandom_range(199);
		if (!pos_jumps || roll < 196)
			frame_pos = frame_pos + pos_stride;
		else if (roll < 198)
			frame_pos = frame_pos + $urandom_range(1 << 25);
		else if (roll < 199)
			frame_pos = frame_pos - $urandom_range(1 << 16);
		else
			frame_pos = $urandom;
	endtask

	task automatic send_frame(input logic [CODE_W-1:0] code);
		advance_position();
		if (code != '0 || run_seen)
			counted_items++;
		run_seen = (code != '0);
		while (frame_gaps && $urandom_range(99) < 13) begin
			frame_ch.valid <= 1'b0;
			@(negedge clk);
		end
		frame_ch.valid <= 1'b1;
		frame_ch.frame_code <= code;
		frame_ch.frame_position <= frame_pos;
		@(posedge clk);
		while (!frame_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// A run that should prune down to the given symbol, now and then with stray tones.
	task automatic send_run(input logic [CODE_W-1:0] symbol);
		logic [CODE_W-1:0] code;
		repeat ($urandom_range(1, 5)) begin
			code = symbol;
			if (code == '0 || $urandom_range(99) < 15)
				code = code | CODE_W'($urandom_range(1, 127));
			send_frame(code);
		end
		repeat ($urandom_range(1, 3))
			send_frame(CODE_W'(0));
	endtask

	task automatic send_message();
		send_run(start_now);
		repeat (3)
			send_run(($urandom_range(99) < 15) ? start_now : CODE_W'($urandom));
	endtask

	task automatic send_noise();
		logic [CODE_W-1:0] code;
		repeat ($urandom_range(2, 12)) begin
			code = ($urandom_range(99) < 30) ? CODE_W'(0) : CODE_W'($urandom);
			send_frame(code);
		end
	endtask

	task automatic settle();
		frame_ch.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES)
			@(negedge clk);
	endtask

	task automatic write_register(input cfg_reg_t index, input logic [GAP_CFG_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= index;
		cfg_ch.data <= value;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic configure(input logic [TONES_W-1:0] tones, input logic [CODE_W-1:0] code,
		input logic [GAP_CFG_W-1:0] gap);
		write_register(CFG_MAX_TONES, GAP_CFG_W'(tones));
		write_register(CFG_START_CODE, GAP_CFG_W'(code));
		write_register(CFG_MAX_GAP, gap);
		cfg_ch.valid <= 1'b0;
		start_now = code;
	endtask

	task automatic run_phase(input int items, input bit with_hold);
		int stop;
		bit held;
		stop = counted_items + items;
		held = 1'b0;
		while (counted_items < stop) begin
			if (with_hold && !held && counted_items > stop - items / 2) begin
				hold_request = HOLD_CYCLES;
				held = 1'b1;
			end
			if ($urandom_range(99) < 85)
				send_message();
			else
				send_noise();
		end
		send_frame(CODE_W'(0));
		settle();
	endtask

	initial begin
		int unsigned tones_pick;
		logic [CODE_W-1:0] code_pick;
		arst_n = 1'b0;
		frame_ch.valid = 1'b0;
		frame_ch.frame_code = '0;
		frame_ch.frame_position = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_MAX_TONES;
		cfg_ch.data = '0;
		repeat (4)
			@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (DIRECTED_CODES[i])
			send_frame(DIRECTED_CODES[i]);
		settle();

		frame_gaps = 1'b0;
		message_gaps = 1'b0;
		pos_jumps = 1'b1;
		frame_pos = $urandom;
		configure(3'd7, 7'd127, 24'hFFFFFF);
		run_phase(400, 1'b0);

		frame_gaps = 1'b1;
		message_gaps = 1'b1;
		configure(3'd1, 7'h40, 24'hFFFFFF);
		run_phase(350, 1'b0);

		pos_jumps = 1'b0;
		pos_stride = 0;
		configure(3'd0, 7'd0, 24'd0);
		run_phase(300, 1'b0);

		pos_jumps = 1'b1;
		pos_stride = 256;
		tones_pick = $urandom_range(1, 6);
		do
			code_pick = CODE_W'($urandom);
		while ($countones(code_pick) > tones_pick);
		configure(TONES_W'(tones_pick), code_pick, MAX_GAP_RESET);
		run_phase(500, 1'b1);

		configure(3'd2, 7'd18, GAP_CFG_W'($urandom_range(300, 5000)));
		run_phase(450, 1'b0);

		if (fail_count == 0 && pending == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule
`default_nettype wire

[sim.f]
+incdir+rtl
rtl/tcrd_pkg.sv
rtl/tcrd_frame_if.sv
rtl/tcrd_message_if.sv
rtl/tcrd_cfg_if.sv
rtl/tone_code_run_deframer_top.sv
tb/tone_code_run_deframer_checker.sv
tb/tone_code_run_deframer_top_test.sv
